### sv/etm_pkg.sv
`default_nettype none
package etm_pkg;

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
  } etm_in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } etm_out_t;

  // Valid bit and the "tone-mapped value is zero" flag that travel with a sample.
  typedef struct packed {
    logic valid;
    logic zero;
  } etm_ctl_t;

  // One level of the power-of-two series pipeline.
  typedef struct packed {
    logic [31:0] term;
    logic [31:0] x;
    logic [33:0] sum;
    logic [5:0]  sh;
    logic        big;
  } etm_p2_t;

  // One level of the logarithm pipeline.
  typedef struct packed {
    logic [31:0] z;
    logic [4:0]  k;
    logic [15:0] frac;
    logic        one;
  } etm_lg_t;

  localparam logic [7:0] CFG_EXPOSURE  = 8'd0;
  localparam logic [7:0] CFG_INV_GAMMA = 8'd1;

  localparam logic [15:0] EXPOSURE_RST  = 16'd256;
  localparam logic [15:0] INV_GAMMA_RST = 16'd1862;

  localparam logic [31:0] LOG2E_Q31 = 32'd3098164009;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;

  localparam int unsigned TAYLOR_TERMS = 12;
  localparam int unsigned NORM_STEPS   = 5;
  localparam int unsigned SQ_STEPS     = 16;
  localparam int unsigned LANES        = 3;

  // ceil(2^36 / i): floor(a / i) equals (a * recip(i)) >> 36 for any 32-bit a.
  function automatic logic [35:0] recip(input logic [3:0] i);
    logic [35:0] r;
    case (i)
      4'd2:    r = 36'd34359738368;
      4'd3:    r = 36'd22906492246;
      4'd4:    r = 36'd17179869184;
      4'd5:    r = 36'd13743895348;
      4'd6:    r = 36'd11453246123;
      4'd7:    r = 36'd9817068106;
      4'd8:    r = 36'd8589934592;
      4'd9:    r = 36'd7635497416;
      4'd10:   r = 36'd6871947674;
      4'd11:   r = 36'd6247225158;
      4'd12:   r = 36'd5726623062;
      default: r = 36'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/etm_pow2.sv
`default_nettype none
module etm_pow2 (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire etm_pkg::etm_ctl_t ctl_i,
  input  wire logic [32:0]      w_i,
  output etm_pkg::etm_ctl_t     ctl_o,
  output logic [32:0]           p_o
);

  localparam int unsigned NT = etm_pkg::TAYLOR_TERMS;

  etm_pkg::etm_p2_t  b_q [NT];
  etm_pkg::etm_ctl_t cb_q [NT];
  etm_pkg::etm_p2_t  a_q [NT-1];
  etm_pkg::etm_ctl_t ca_q [NT-1];
  etm_pkg::etm_p2_t  b0_d;
  logic [47:0]       xp;
  logic [33:0]       shifted;
  logic [32:0]       p_d;
  logic [32:0]       p_q;
  etm_pkg::etm_ctl_t co_q;

  // First term of the series is x itself, already subtracted from one.
  always_comb begin
    xp        = 48'(w_i[15:0]) * 48'(etm_pkg::LN2_Q32);
    b0_d.x    = xp[47:16];
    b0_d.term = xp[47:16];
    b0_d.sum  = 34'h1_0000_0000 - {2'b00, xp[47:16]};
    b0_d.sh   = w_i[21:16];
    b0_d.big  = (w_i[32:16] >= 17'd33);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q[0] <= '0;
    end else if (en_i) begin
      cb_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q[0] <= b0_d;
    end
  end

  for (genvar gi = 0; gi < NT - 1; gi++) begin : g_term
    localparam int unsigned I = gi + 2;
    logic [63:0]      prod;
    logic [67:0]      qp;
    etm_pkg::etm_p2_t a_d;
    etm_pkg::etm_p2_t b_d;

    always_comb begin
      prod   = 64'(b_q[gi].term) * 64'(b_q[gi].x);
      a_d    = b_q[gi];
      a_d.term = prod[63:32];
    end

    always_comb begin
      qp     = 68'(a_q[gi].term) * 68'(etm_pkg::recip(4'(I)));
      b_d    = a_q[gi];
      b_d.term = qp[67:36];
      if ((I % 2) == 1) begin
        b_d.sum = a_q[gi].sum - {2'b00, qp[67:36]};
      end else begin
        b_d.sum = a_q[gi].sum + {2'b00, qp[67:36]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ca_q[gi]   <= '0;
        cb_q[gi+1] <= '0;
      end else if (en_i) begin
        ca_q[gi]   <= cb_q[gi];
        cb_q[gi+1] <= ca_q[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[gi]   <= a_d;
        b_q[gi+1] <= b_d;
      end
    end
  end

  always_comb begin
    shifted = b_q[NT-1].sum >> b_q[NT-1].sh;
    p_d     = b_q[NT-1].big ? '0 : shifted[32:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      co_q <= '0;
    end else if (en_i) begin
      co_q <= cb_q[NT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign ctl_o = co_q;
  assign p_o   = p_q;

endmodule
`default_nettype wire

### sv/etm_log2.sv
`default_nettype none
module etm_log2 (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire etm_pkg::etm_ctl_t ctl_i,
  input  wire logic [32:0]      m_i,
  output etm_pkg::etm_ctl_t     ctl_o,
  output logic [21:0]           l_o
);

  localparam int unsigned NS = etm_pkg::NORM_STEPS;
  localparam int unsigned SQ = etm_pkg::SQ_STEPS;
  localparam int unsigned NL = 1 + NS + SQ;

  etm_pkg::etm_lg_t  g_q [NL];
  etm_pkg::etm_ctl_t c_q [NL];
  etm_pkg::etm_lg_t  g0_d;
  logic [21:0]       l_d;
  logic [21:0]       l_q;
  etm_pkg::etm_ctl_t co_q;

  always_comb begin
    g0_d.z    = m_i[31:0];
    g0_d.k    = '0;
    g0_d.frac = '0;
    g0_d.one  = m_i[32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q[0] <= '0;
    end else if (en_i) begin
      c_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_q[0] <= g0_d;
    end
  end

  // Leading-zero normalisation, one binary step per stage.
  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int unsigned SH = 16 >> j;
    etm_pkg::etm_lg_t d;

    always_comb begin
      d = g_q[j];
      if (g_q[j].z[31 -: SH] == '0) begin
        d.z = g_q[j].z << SH;
        d.k = g_q[j].k + 5'(SH);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_q[j+1] <= '0;
      end else if (en_i) begin
        c_q[j+1] <= c_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        g_q[j+1] <= d;
      end
    end
  end

  // Each squaring of the mantissa yields one fraction bit of its logarithm.
  for (genvar s = 0; s < SQ; s++) begin : g_sq
    localparam int unsigned L = 1 + NS + s;
    logic [63:0]      sq;
    etm_pkg::etm_lg_t d;

    always_comb begin
      sq = 64'(g_q[L-1].z) * 64'(g_q[L-1].z);
      d  = g_q[L-1];
      if (sq[63]) begin
        d.frac = {g_q[L-1].frac[14:0], 1'b1};
        d.z    = sq[63:32];
      end else begin
        d.frac = {g_q[L-1].frac[14:0], 1'b0};
        d.z    = sq[62:31];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_q[L] <= '0;
      end else if (en_i) begin
        c_q[L] <= c_q[L-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        g_q[L] <= d;
      end
    end
  end

  always_comb begin
    if (g_q[NL-1].one) begin
      l_d = '0;
    end else begin
      l_d = {6'(g_q[NL-1].k) + 6'd1, 16'h0000} - 22'(g_q[NL-1].frac);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      co_q <= '0;
    end else if (en_i) begin
      co_q <= c_q[NL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q <= l_d;
    end
  end

  assign ctl_o = co_q;
  assign l_o   = l_q;

endmodule
`default_nettype wire

### sv/etm_lane.sv
`default_nettype none
module etm_lane (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [15:0] c_i,
  input  wire logic [15:0] exposure_i,
  input  wire logic [15:0] inv_gamma_i,
  output logic             valid_o,
  output logic [15:0]      y_o
);

  etm_pkg::etm_ctl_t c1_q, c2_q, ce, c3_q, cl, c4_q, cr;
  logic        v5_q;
  logic [31:0] t_q;
  logic [63:0] up;
  logic [32:0] u_q;
  logic [32:0] e;
  logic [32:0] m_d, m_q;
  logic [21:0] l;
  logic [37:0] vp;
  logic [32:0] v_q;
  logic [32:0] r;
  logic [33:0] rnd;
  logic [15:0] y_d, y_q;

  assign up  = 64'(t_q) * 64'(etm_pkg::LOG2E_Q31);
  assign m_d = 33'h1_0000_0000 - e;
  assign vp  = 38'(l) * 38'(inv_gamma_i);

  always_comb begin
    rnd = 34'(r) + 34'h0_0000_8000;
    if (cr.zero) begin
      y_d = '0;
    end else if (rnd[33:32] != 2'b00) begin
      y_d = 16'hFFFF;
    end else begin
      y_d = rnd[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      c1_q <= '{valid: valid_i, zero: 1'b0};
      c2_q <= c1_q;
      c3_q <= '{valid: ce.valid, zero: (m_d == '0)};
      c4_q <= cl;
      v5_q <= cr.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= 32'(exposure_i) * 32'(c_i);
      u_q <= up[63:31];
      m_q <= m_d;
      v_q <= 33'(vp[37:12]);
      y_q <= y_d;
    end
  end

  etm_pow2 u_exp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en_i),
    .ctl_i (c2_q),
    .w_i   (u_q),
    .ctl_o (ce),
    .p_o   (e)
  );

  etm_log2 u_log (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en_i),
    .ctl_i (c3_q),
    .m_i   (m_q),
    .ctl_o (cl),
    .l_o   (l)
  );

  etm_pow2 u_gam (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en_i),
    .ctl_i (c4_q),
    .w_i   (v_q),
    .ctl_o (cr),
    .p_o   (r)
  );

  assign valid_o = v5_q;
  assign y_o     = y_q;

endmodule
`default_nettype wire

### sv/etm_merge.sv
`default_nettype none
module etm_merge (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [2:0]        lane_valid_i,
  input  wire etm_pkg::etm_out_t res_i,
  output logic                   en_o,
  output logic                   out_valid_o,
  output etm_pkg::etm_out_t      out_data_o,
  input  wire logic              out_stall_i
);

  logic              p_v;
  logic              o_v_q, s_v_q;
  etm_pkg::etm_out_t o_q, s_q;
  logic              take;

  assign p_v  = &lane_valid_i;
  assign take = o_v_q && !out_stall_i;
  // The lanes only move while the skid register is empty.
  assign en_o = !s_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
      s_v_q <= 1'b0;
    end else if (s_v_q) begin
      if (take) begin
        s_v_q <= 1'b0;
      end
    end else if (!o_v_q || take) begin
      o_v_q <= p_v;
    end else if (p_v) begin
      s_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_v_q) begin
      if (take) begin
        o_q <= s_q;
      end
    end else if (!o_v_q || take) begin
      o_q <= res_i;
    end else begin
      s_q <= res_i;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_q;

  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_valid_i[0] == lane_valid_i[1]) && (lane_valid_i[1] == lane_valid_i[2]))
    else $error("lane valid bits disagree");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_v_q |-> o_v_q)
    else $error("skid register full while output empty");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_v_q && p_v && o_v_q && out_stall_i) |=> (s_v_q && o_v_q))
    else $error("stalled request was not parked");

endmodule
`default_nettype wire

### sv/exp_tone_map_gamma.sv
`default_nettype none
// Exponential tone mapping with gamma correction, one HDR pixel per request.
// Input channel: in_valid_i / in_stall_o with in_data_i holding red, green and
// blue radiance in unsigned Q8.8. Output channel: out_valid_o / out_stall_i
// with out_data_o holding the three display values in unsigned Q0.16.
// A request moves when valid is high and stall is low at a rising edge.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 exposure,
// 1 inverse gamma) and cfg_data_i; ready is always high, other indexes are
// ignored. Write registers only while no pixel is in flight.
// Each colour has its own lane; the output stage merges the three results.
// The path from acceptance to out_valid_o runs through the three fixed-point
// units of a lane (series exponential of 24 stages, logarithm of 23 stages,
// second exponential of 24 stages) plus the glue stages.
// Throughput is one pixel per cycle while the receiver takes results.
// When the receiver stalls, one further result is parked in a skid register
// and the lanes then freeze; in_stall_o is high exactly while it is full.
// Reset empties the pipeline and loads exposure 1.0 and inverse gamma 1862.
module exp_tone_map_gamma (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire etm_pkg::etm_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output etm_pkg::etm_out_t      out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [7:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_data_i
);

  logic [15:0]       exposure_q, inv_gamma_q;
  logic              en;
  logic              acc;
  logic [2:0]        lane_valid;
  etm_pkg::etm_out_t res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !en;
  assign acc         = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exposure_q  <= etm_pkg::EXPOSURE_RST;
      inv_gamma_q <= etm_pkg::INV_GAMMA_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        etm_pkg::CFG_EXPOSURE:  exposure_q  <= cfg_data_i;
        etm_pkg::CFG_INV_GAMMA: inv_gamma_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  etm_lane u_red (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (acc),
    .c_i        (in_data_i.red_in),
    .exposure_i (exposure_q),
    .inv_gamma_i(inv_gamma_q),
    .valid_o    (lane_valid[0]),
    .y_o        (res.red_out)
  );

  etm_lane u_green (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (acc),
    .c_i        (in_data_i.green_in),
    .exposure_i (exposure_q),
    .inv_gamma_i(inv_gamma_q),
    .valid_o    (lane_valid[1]),
    .y_o        (res.green_out)
  );

  etm_lane u_blue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (acc),
    .c_i        (in_data_i.blue_in),
    .exposure_i (exposure_q),
    .inv_gamma_i(inv_gamma_q),
    .valid_o    (lane_valid[2]),
    .y_o        (res.blue_out)
  );

  etm_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lane_valid_i(lane_valid),
    .res_i       (res),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
`default_nettype wire
